// File: design/bru_pkg.sv
// Package with the branch operation codes and the request and result records.
package bru_pkg;

  // Branch kinds carried in the operation field.
  typedef enum logic [1:0] {
    OP_B     = 2'd0,
    OP_BC    = 2'd1,
    OP_BCLR  = 2'd2,
    OP_BCCTR = 2'd3
  } bru_op_t;

  localparam int unsigned WordWidth = 32;

  // Clears the two low bits of a register-sourced target.
  localparam logic [WordWidth-1:0] AlignMask = 32'hffff_fffc;

  // Distance from a branch to the instruction after it.
  localparam logic [WordWidth-1:0] InstrBytes = 32'd4;

  // One branch request as held in the input register.
  typedef struct packed {
    bru_op_t              operation;
    logic [WordWidth-1:0] instruction;
    logic [WordWidth-1:0] pc;
    logic [WordWidth-1:0] ctr_in;
    logic [WordWidth-1:0] lr_in;
    logic [WordWidth-1:0] cr_bits;
  } bru_req_t;

  // One resolved branch as held in the result register.
  typedef struct packed {
    logic [WordWidth-1:0] next_pc;
    logic [WordWidth-1:0] ctr_out;
    logic [WordWidth-1:0] lr_out;
    logic                 taken;
  } bru_rsp_t;

endpackage

// File: design/bru_if.sv
// Valid/ready channel interfaces for branch requests and branch results.
interface bru_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] instruction;
  logic [31:0] pc;
  logic [31:0] ctr_in;
  logic [31:0] lr_in;
  logic [31:0] cr_bits;

  modport source (
    output valid, operation, instruction, pc, ctr_in, lr_in, cr_bits,
    input  ready
  );
  modport sink (
    input  valid, operation, instruction, pc, ctr_in, lr_in, cr_bits,
    output ready
  );
endinterface

interface bru_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [31:0] ctr_out;
  logic [31:0] lr_out;
  logic        taken;

  modport source (
    output valid, next_pc, ctr_out, lr_out, taken,
    input  ready
  );
  modport sink (
    input  valid, next_pc, ctr_out, lr_out, taken,
    output ready
  );
endinterface

// File: design/bru_resolve.sv
// Combinational branch resolution: conditions, CTR update, target and link.
module bru_resolve
  import bru_pkg::*;
(
  input  bru_req_t req,
  output bru_rsp_t rsp
);

  logic [4:0]           bi;
  logic                 bo_no_cr;
  logic                 bo_cr_val;
  logic                 bo_no_ctr;
  logic                 bo_ctr_zero;
  logic                 aa;
  logic                 lk;
  logic [WordWidth-1:0] link;
  logic [WordWidth-1:0] li_ext;
  logic [WordWidth-1:0] bd_ext;
  logic [WordWidth-1:0] ctr_dec;
  logic                 cr_sel;
  logic                 cond_ok;
  logic                 ctr_ok;
  logic [WordWidth-1:0] target;
  logic                 taken;
  logic [WordWidth-1:0] ctr_next;

  // Instruction fields; BO bits are named by their role.
  assign bo_no_cr    = req.instruction[25];
  assign bo_cr_val   = req.instruction[24];
  assign bo_no_ctr   = req.instruction[23];
  assign bo_ctr_zero = req.instruction[22];
  assign bi          = req.instruction[20:16];
  assign aa          = req.instruction[1];
  assign lk          = req.instruction[0];

  // Sign-extended word offsets of the I-form and B-form words.
  assign li_ext = {{6{req.instruction[25]}}, req.instruction[25:2], 2'b00};
  assign bd_ext = {{16{req.instruction[15]}}, req.instruction[15:2], 2'b00};

  assign link    = req.pc + InstrBytes;
  assign ctr_dec = req.ctr_in - 32'd1;

  // CR bit 0 sits in the most significant bit of the register.
  assign cr_sel  = req.cr_bits[5'd31 - bi];
  assign cond_ok = bo_no_cr || (cr_sel == bo_cr_val);

  // The count test looks at the decremented value.
  assign ctr_ok = bo_no_ctr || ((ctr_dec != '0) != bo_ctr_zero);

  // Per-kind target, taken decision and count update.
  always_comb begin
    target   = link;
    taken    = 1'b0;
    ctr_next = req.ctr_in;
    case (req.operation)
      OP_B: begin
        target = aa ? li_ext : li_ext + req.pc;
        taken  = 1'b1;
      end
      OP_BC: begin
        target = aa ? bd_ext : bd_ext + req.pc;
        taken  = ctr_ok && cond_ok;
        if (!bo_no_ctr) begin
          ctr_next = ctr_dec;
        end
      end
      OP_BCLR: begin
        target = req.lr_in & AlignMask;
        taken  = ctr_ok && cond_ok;
        if (!bo_no_ctr) begin
          ctr_next = ctr_dec;
        end
      end
      OP_BCCTR: begin
        target = req.ctr_in & AlignMask;
        taken  = cond_ok;
      end
      default: begin
        target   = link;
        taken    = 1'b0;
        ctr_next = req.ctr_in;
      end
    endcase
  end

  // The link is written whether or not the branch goes.
  assign rsp.next_pc = taken ? target : link;
  assign rsp.ctr_out = ctr_next;
  assign rsp.lr_out  = lk ? link : req.lr_in;
  assign rsp.taken   = taken;

endmodule

// File: design/branch_resolve_unit.sv
// Top level of the branch resolution unit: input register, resolve logic, result register.
//
//   channel | dir | carries                                          | accepted when
//   req     | in  | operation, instruction, pc, ctr_in, lr_in, cr_bits | req.valid && req.ready
//   rsp     | out | next_pc, ctr_out, lr_out, taken                    | rsp.valid && rsp.ready
//
// An accepted request is held in the input register, where the resolve logic works on it;
// its result enters the result register, which drives rsp, once that register is free or
// being drained. One request is accepted per cycle while the result side does not stall;
// the rate is set by the single pass of resolve logic between the two registers.
// A stalled result holds the result register and lets one more request wait in the
// input register before req.ready drops. Synchronous reset empties both registers.
module branch_resolve_unit
  import bru_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  bru_req_if.sink      req,
  bru_rsp_if.source    rsp
);

  logic     in_valid;
  bru_req_t in_data;
  logic     out_valid;
  bru_rsp_t out_data;
  bru_rsp_t resolved;
  logic     advance;
  logic     req_take;

  // The input stage moves on when the result register is free or being drained.
  assign advance  = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign req_take = req.valid && req.ready;

  // Input register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (req_take) begin
      in_data.operation   <= bru_op_t'(req.operation);
      in_data.instruction <= req.instruction;
      in_data.pc          <= req.pc;
      in_data.ctr_in      <= req.ctr_in;
      in_data.lr_in       <= req.lr_in;
      in_data.cr_bits     <= req.cr_bits;
    end
  end

  bru_resolve u_resolve (
    .req (in_data),
    .rsp (resolved)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= resolved;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.next_pc = out_data.next_pc;
  assign rsp.ctr_out = out_data.ctr_out;
  assign rsp.lr_out  = out_data.lr_out;
  assign rsp.taken   = out_data.taken;

endmodule

// File: design/bru_checker.sv
// Port-level checker for the branch resolution unit and its bind statement.
module bru_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_next_pc,
  input logic        rsp_taken
);

  logic [1:0] outstanding;
  logic       req_take;
  logic       rsp_take;

  assign req_take = req_valid && req_ready;
  assign rsp_take = rsp_valid && rsp_ready;

  // Count requests accepted whose results are not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 2'd0;
    end else if (req_take && !rsp_take) begin
      outstanding <= outstanding + 2'd1;
    end else if (rsp_take && !req_take) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_next_pc) && $stable(rsp_taken)))
    else $error("stalled result changed");

  // No result is shown without a request behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (outstanding != 2'd0))
    else $error("result without an accepted request");

  // The unit holds at most two requests in flight; a full unit with a stalled
  // result must refuse new requests.
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    ((outstanding == 2'd2) && !rsp_ready) |-> !req_ready)
    else $error("request accepted beyond capacity");

  // An empty unit always takes a request.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (outstanding == 2'd0) |-> req_ready)
    else $error("empty unit not ready");

endmodule

bind branch_resolve_unit bru_checker u_bru_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_next_pc (rsp.next_pc),
  .rsp_taken   (rsp.taken)
);

// File: bench/tb_branch_resolve_unit.sv
// Self-checking testbench for the branch resolution unit, with its scoreboard class.
`timescale 1ns / 100ps

module tb_branch_resolve_unit;
  import bru_pkg::*;

  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int IdleLimit = 1000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int LongHold = 80;
  // Request count at which the long hold-off starts.
  localparam int LongHoldStart = 400;
  localparam int RandomRequests = 1600;
  // Final stretch of random requests sent with no idling on either side.
  localparam int CalmRequests = 200;

  // Keeps the resolved branches still owed by the block and checks each result.
  class branch_scoreboard;
    bru_rsp_t owed_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Works out the next pc, CTR, LR and taken flag of one branch.
    function bru_rsp_t resolve(bru_req_t r);
      bru_rsp_t res;
      logic [4:0] bo;
      logic [4:0] bi;
      logic [31:0] link;
      logic [31:0] disp;
      logic [31:0] target;
      logic [31:0] ctr;
      logic cond_ok;
      logic ctr_ok;
      logic taken;
      bo = r.instruction[25:21];
      bi = r.instruction[20:16];
      link = r.pc + InstrBytes;
      ctr = r.ctr_in;
      // CR test: BO[4] bypasses it, otherwise CR bit BI (MSB first) must equal BO[3].
      cond_ok = bo[4] || (r.cr_bits[31 - bi] == bo[3]);
      case (r.operation)
        OP_B: begin
          disp = {{6{r.instruction[25]}}, r.instruction[25:2], 2'b00};
          target = r.instruction[1] ? disp : disp + r.pc;
          taken = 1'b1;
        end
        OP_BCCTR: begin
          // No decrement and no CTR test here; only the CR test decides.
          target = r.ctr_in & AlignMask;
          taken = cond_ok;
        end
        default: begin
          ctr_ok = 1'b1;
          if (!bo[2]) begin
            ctr = ctr - 1;
            ctr_ok = (ctr != 0) != bo[1];
          end
          taken = ctr_ok && cond_ok;
          if (r.operation == OP_BC) begin
            disp = {{16{r.instruction[15]}}, r.instruction[15:2], 2'b00};
            target = r.instruction[1] ? disp : disp + r.pc;
          end else begin
            target = r.lr_in & AlignMask;
          end
        end
      endcase
      res.next_pc = taken ? target : link;
      res.ctr_out = ctr;
      res.lr_out = r.instruction[0] ? link : r.lr_in;
      res.taken = taken;
      return res;
    endfunction

    function void note_request(bru_req_t r);
      owed_q.push_back(resolve(r));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Prints one line per mismatch; printing stops after a hundred to keep the log short.
    task report(string msg);
      if (errors < 100) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    task check_result(bru_rsp_t got);
      bru_rsp_t exp;
      if (owed_q.size() == 0) begin
        report("result arrived with no request outstanding");
        return;
      end
      exp = owed_q.pop_front();
      if (got.next_pc !== exp.next_pc) begin
        report($sformatf("next_pc %h, expected %h", got.next_pc, exp.next_pc));
      end
      if (got.ctr_out !== exp.ctr_out) begin
        report($sformatf("ctr_out %h, expected %h", got.ctr_out, exp.ctr_out));
      end
      if (got.lr_out !== exp.lr_out) begin
        report($sformatf("lr_out %h, expected %h", got.lr_out, exp.lr_out));
      end
      if (got.taken !== exp.taken) begin
        report($sformatf("taken %b, expected %b", got.taken, exp.taken));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bru_req_if req ();
  bru_rsp_if rsp ();
  branch_scoreboard sb = new();

  int requests_sent = 0;
  logic calm = 1'b0;
  logic long_hold_done = 1'b0;
  int quiet_cycles = 0;

  branch_resolve_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Free-running 2 ns clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Builds one request from its fields.
  function automatic bru_req_t make_req(bru_op_t op, logic [31:0] ins, logic [31:0] pc,
                                        logic [31:0] ctr, logic [31:0] lr, logic [31:0] cr);
    bru_req_t r;
    r.operation = op;
    r.instruction = ins;
    r.pc = pc;
    r.ctr_in = ctr;
    r.lr_in = lr;
    r.cr_bits = cr;
    return r;
  endfunction

  // B-form word for bc.
  function automatic logic [31:0] bform(logic [4:0] bo, logic [4:0] bi, logic [13:0] bd,
                                        logic aa, logic lk);
    return {6'd16, bo, bi, bd, aa, lk};
  endfunction

  // XL-form word for bclr and bcctr; the five unused bits are given explicitly.
  function automatic logic [31:0] xlform(logic [4:0] bo, logic [4:0] bi, logic [4:0] spare,
                                         logic [9:0] xo, logic lk);
    return {6'd19, bo, bi, spare, xo, lk};
  endfunction

  // Random request, with CTR values near zero favored so the count test flips often.
  function automatic bru_req_t random_request();
    logic [31:0] ctr;
    logic [31:0] pc;
    case ($urandom_range(0, 7))
      0: ctr = 32'd0;
      1: ctr = 32'd1;
      2: ctr = 32'd2;
      3: ctr = 32'hffff_ffff;
      default: ctr = $urandom;
    endcase
    pc = ($urandom_range(0, 7) == 0) ? (32'hffff_fff0 | ($urandom & 32'hc)) : $urandom;
    return make_req(bru_op_t'($urandom_range(0, 3)), $urandom, pc, ctr, $urandom, $urandom);
  endfunction

  // Offers one request and returns at the edge where it is accepted.
  task send_request(bru_req_t r);
    req.valid <= 1'b1;
    req.operation <= r.operation;
    req.instruction <= r.instruction;
    req.pc <= r.pc;
    req.ctr_in <= r.ctr_in;
    req.lr_in <= r.lr_in;
    req.cr_bits <= r.cr_bits;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Drops valid for a random burst now and then, never in the calm stretch.
  task maybe_pause();
    if (!calm && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stimulus: reset, directed corner cases, random requests, then drain.
  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.operation <= OP_B;
    req.instruction <= '0;
    req.pc <= '0;
    req.ctr_in <= '0;
    req.lr_in <= '0;
    req.cr_bits <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Unconditional branches: LI extremes, absolute and relative, link, pc wrap.
    send_request(make_req(OP_B, {6'd18, 24'h7f_ffff, 2'b00}, 32'h0000_1000, 32'd7,
                          32'h1111_1111, 32'h0));
    send_request(make_req(OP_B, {6'd18, 24'h80_0000, 2'b11}, 32'h0000_1000, 32'd7,
                          32'h1111_1111, 32'h0));
    send_request(make_req(OP_B, {6'd18, 24'h00_0001, 2'b01}, 32'hffff_fffc, 32'd0,
                          32'h2222_2222, 32'h0));
    send_request(make_req(OP_B, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff));
    send_request(make_req(OP_B, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0));
    maybe_pause();

    // Conditional branches: BD extremes, absolute target, count and CR tests.
    send_request(make_req(OP_BC, bform(5'b10100, 5'd0, 14'h1fff, 1'b0, 1'b0), 32'h0000_2000,
                          32'd9, 32'h3333_3333, 32'h0));
    send_request(make_req(OP_BC, bform(5'b10100, 5'd0, 14'h2000, 1'b1, 1'b1), 32'h0000_2000,
                          32'd9, 32'h3333_3333, 32'h0));
    // Decrement to zero and branch on zero.
    send_request(make_req(OP_BC, bform(5'b10010, 5'd4, 14'h0010, 1'b0, 1'b0), 32'h0000_4000,
                          32'd1, 32'h0, 32'h0));
    // Decrement to zero, branch on nonzero: not taken, LR still written.
    send_request(make_req(OP_BC, bform(5'b10000, 5'd4, 14'h0010, 1'b0, 1'b1), 32'h0000_4000,
                          32'd1, 32'h4444_4444, 32'h0));
    // Decrementing zero wraps to all ones.
    send_request(make_req(OP_BC, bform(5'b10000, 5'd4, 14'h3ff0, 1'b0, 1'b0), 32'h0000_0008,
                          32'd0, 32'h0, 32'h0));
    // CR true test on the first CR bit, CR false test on the last one.
    send_request(make_req(OP_BC, bform(5'b01100, 5'd0, 14'h0020, 1'b0, 1'b0), 32'h0000_5000,
                          32'd3, 32'h0, 32'h8000_0000));
    send_request(make_req(OP_BC, bform(5'b00100, 5'd31, 14'h0020, 1'b0, 1'b0), 32'h0000_5000,
                          32'd3, 32'h0, 32'h0000_0001));
    send_request(make_req(OP_BC, bform(5'b01000, 5'd5, 14'h0040, 1'b0, 1'b1), 32'h0000_6000,
                          32'd2, 32'h0, 32'h0400_0000));
    send_request(make_req(OP_BC, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_request(make_req(OP_BC, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff));
    maybe_pause();

    // Branch to LR: old LR is the target even when linking; AA is ignored.
    send_request(make_req(OP_BCLR, xlform(5'b10100, 5'd0, 5'd0, 10'd16, 1'b1), 32'h0000_7000,
                          32'd5, 32'h1234_5677, 32'h0));
    send_request(make_req(OP_BCLR, xlform(5'b10000, 5'd0, 5'd0, 10'd16, 1'b0) | 32'h2,
                          32'h0000_7000, 32'd1, 32'h1234_5677, 32'h0));
    // Unused XL-form bits set.
    send_request(make_req(OP_BCLR, xlform(5'b01100, 5'd3, 5'h1f, 10'd16, 1'b0), 32'h0000_7000,
                          32'd5, 32'hffff_ffff, 32'h1000_0000));

    // Branch to CTR: no decrement even when BO asks for one; only the CR test counts.
    send_request(make_req(OP_BCCTR, xlform(5'b10100, 5'd0, 5'd0, 10'd528, 1'b1), 32'h0000_8000,
                          32'hdead_beef, 32'h0, 32'h0));
    send_request(make_req(OP_BCCTR, xlform(5'b00000, 5'd2, 5'd0, 10'd528, 1'b0), 32'h0000_8000,
                          32'd5, 32'h0, 32'h0));
    send_request(make_req(OP_BCCTR, xlform(5'b01100, 5'd2, 5'h1f, 10'd528, 1'b0) | 32'h2,
                          32'h0000_8000, 32'd0, 32'h0, 32'h0));
    send_request(make_req(OP_BCCTR, 32'hffff_ffff, 32'hffff_fffc, 32'hffff_ffff, 32'h0,
                          32'h0));

    // Random requests; the last stretch runs with no idling.
    for (int i = 0; i < RandomRequests; i++) begin
      if (i == RandomRequests - CalmRequests) begin
        calm <= 1'b1;
      end
      maybe_pause();
      send_request(random_request());
    end
    req.valid <= 1'b0;

    // Drain, then allow the pipeline to settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random ready bursts, one long hold-off, steady ready at the end.
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end else if (!long_hold_done && requests_sent >= LongHoldStart) begin
        rsp.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Watches both channels: records accepted requests and checks accepted results.
  always @(posedge clk) begin : watch
    bru_req_t seen_req;
    bru_rsp_t seen_rsp;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        seen_rsp.next_pc = rsp.next_pc;
        seen_rsp.ctr_out = rsp.ctr_out;
        seen_rsp.lr_out = rsp.lr_out;
        seen_rsp.taken = rsp.taken;
        sb.check_result(seen_rsp);
      end
      if (req.valid && req.ready) begin
        seen_req = make_req(bru_op_t'(req.operation), req.instruction, req.pc, req.ctr_in,
                            req.lr_in, req.cr_bits);
        sb.note_request(seen_req);
      end
    end
  end

  // Hang detection: too many cycles without any handshake ends the run.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
